// File: design/touch_packet_tracker_defines.svh
// ----------------------------------------------------------------------------
// Touch packet tracker assertion macros
// Shared checking macros for the tracker RTL.
// ----------------------------------------------------------------------------
`ifndef TOUCH_PACKET_TRACKER_DEFINES_SVH
`define TOUCH_PACKET_TRACKER_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define TPT_CHECK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check a property on every clock edge, reset included.
`define TPT_CHECK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: design/tpt_pkg.sv
// ----------------------------------------------------------------------------
// Touch packet tracker package
// Constants, register indexes and sequencer codes for the tracker.
// ----------------------------------------------------------------------------
package tpt_pkg;

  localparam int COORD_BITS = 10;

  // Configuration register indexes
  localparam logic [1:0] REG_SCAN_PERIOD   = 2'd0;
  localparam logic [1:0] REG_RELEASE_WAIT  = 2'd1;
  localparam logic [1:0] REG_SLEEP_WAIT    = 2'd2;
  localparam logic [1:0] REG_POLL_INTERVAL = 2'd3;

  // Register reset values
  localparam logic [3:0]  RST_PERIOD  = 4'd5;
  localparam logic [7:0]  RST_RELEASE = 8'd20;
  localparam logic [12:0] RST_SLEEP   = 13'd5000;
  localparam logic [15:0] RST_POLL    = 16'd30000;

  // Packet byte layout
  localparam int SYNC_BIT = 7;
  localparam int PEN_BIT  = 6;

  // Period handling
  localparam logic [3:0] MAX_PERIOD    = 4'd10;
  localparam logic [6:0] SLEEP_TICK_MS = 7'd100;

  // Packet phases
  localparam logic [1:0] PH_HEAD   = 2'd0;
  localparam logic [1:0] PH_MIDDLE = 2'd1;
  localparam logic [1:0] PH_LAST   = 2'd2;

  // Divider: 13-bit dividend, one quotient bit per cycle
  localparam int         DIV_BITS = 13;
  localparam logic [3:0] DIV_LAST = 4'd12;

  // Sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_DIV  = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

endpackage

// File: design/touch_packet_tracker.sv
// ----------------------------------------------------------------------------
// Touch packet tracker
// Assembles three-byte touch packets, times pen release, sleep and polls.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall, byte_present, rx_byte) carries one
//   request per polling tick. Output channel (out_valid / out_stall) returns
//   exactly one result per tick: report fields, asleep, next_tick_ms and
//   status_poll.
//   Configuration is a plain write port (write_en, write_index, write_data);
//   write it only while no tick is in flight.
//   The accepting edge does the byte and release handling; the shared
//   one-bit-per-cycle restoring divider then takes 13 steps for
//   release_wait, then 13 for sleep_wait, both divided by the effective
//   period (by one when asleep or the period is zero), and the final step
//   does the sleep and poll checks and loads the output register. A new tick
//   is taken only once the sequencer is back in its idle state; ticks never
//   overlap. in_stall is high while a tick is being worked on.
//   If the receiver stalls, the finished result holds in the output register
//   and the sequencer waits in its final step; a new tick is accepted once
//   the previous result has moved into the output register.
//   Reset (rst, synchronous) restores register defaults (period 5, release
//   20, sleep 5000, poll 30000), clears counters and the packet phase, and
//   empties the output register.
// ----------------------------------------------------------------------------
module touch_packet_tracker import tpt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // configuration writes
  input  logic                  write_en,
  input  logic [1:0]            write_index,
  input  logic [15:0]           write_data,
  // tick requests
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  byte_present,
  input  logic [7:0]            rx_byte,
  // results
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  report_valid,
  output logic                  pen_down,
  output logic [COORD_BITS-1:0] pos_x,
  output logic [COORD_BITS-1:0] pos_y,
  output logic                  asleep,
  output logic [6:0]            next_tick_ms,
  output logic                  status_poll
);

  `include "touch_packet_tracker_defines.svh"

  // Configuration registers
  logic [3:0]  scan_period;
  logic [7:0]  release_wait;
  logic [12:0] sleep_wait;
  logic [15:0] poll_interval;

  // Tracker state
  logic [1:0]            packet_phase;
  logic [7:0]            head_byte;
  logic [6:0]            middle_byte;
  logic [COORD_BITS-1:0] last_x;
  logic [COORD_BITS-1:0] last_y;
  logic                  pressed;
  logic [8:0]            release_count;
  logic [7:0]            release_limit;
  logic [12:0]           sleep_limit;
  logic [13:0]           idle_count;
  logic                  sleeping;
  logic [16:0]           poll_count;

  // Per-tick working registers
  logic [1:0] state;
  logic       rep;
  logic       rep_pen;
  logic [6:0] tick_ms;

  // Shared divider
  logic [DIV_BITS-1:0] div_quo;
  logic [3:0]          div_rem;
  logic [3:0]          div_den;
  logic [3:0]          div_cnt;
  logic                div_sel;   // 0: release limit, 1: sleep limit

  logic                accept;
  logic [3:0]          eff_period;
  logic                sleeping_next;
  logic [4:0]          div_shift;
  logic                div_ge;
  logic [3:0]          div_rem_next;
  logic [DIV_BITS-1:0] div_quo_next;
  logic                out_free;
  logic                fin_sleep;
  logic                fin_poll;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // Clamp the period and note the sleep state after byte handling
  assign eff_period    = (scan_period > MAX_PERIOD) ? MAX_PERIOD : scan_period;
  assign sleeping_next = byte_present ? 1'b0 : sleeping;

  // One restoring division step: shift in the next dividend bit, subtract
  assign div_shift    = {div_rem, div_quo[DIV_BITS-1]};
  assign div_ge       = (div_shift >= {1'b0, div_den});
  assign div_rem_next = div_ge ? 4'(div_shift - {1'b0, div_den}) : div_shift[3:0];
  assign div_quo_next = {div_quo[DIV_BITS-2:0], div_ge};

  // Sleep and poll decisions of the final step
  assign fin_sleep = (idle_count > {1'b0, sleep_limit});
  assign fin_poll  = (poll_count > {1'b0, poll_interval});

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_period   <= RST_PERIOD;
      release_wait  <= RST_RELEASE;
      sleep_wait    <= RST_SLEEP;
      poll_interval <= RST_POLL;
    end else if (write_en) begin
      unique case (write_index)
        REG_SCAN_PERIOD:   scan_period   <= write_data[3:0];
        REG_RELEASE_WAIT:  release_wait  <= write_data[7:0];
        REG_SLEEP_WAIT:    sleep_wait    <= write_data[12:0];
        REG_POLL_INTERVAL: poll_interval <= write_data;
        default: ;
      endcase
    end
  end

  // Sequencer and tracker state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      packet_phase  <= PH_HEAD;
      last_x        <= '0;
      last_y        <= '0;
      pressed       <= 1'b0;
      release_count <= '0;
      release_limit <= RST_RELEASE;
      sleep_limit   <= RST_SLEEP;
      idle_count    <= '0;
      sleeping      <= 1'b0;
      poll_count    <= '0;
      out_valid     <= 1'b0;
    end else begin
      // load a finished result, or drop the result once it is taken
      if ((state == S_FIN) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            rep     <= 1'b0;
            rep_pen <= 1'b0;
            if (byte_present) begin
              sleeping   <= 1'b0;
              idle_count <= '0;
              unique case (packet_phase)
                PH_MIDDLE: begin
                  if (!rx_byte[SYNC_BIT]) begin
                    middle_byte  <= rx_byte[6:0];
                    packet_phase <= PH_LAST;
                  end
                end
                PH_LAST: begin
                  if (!rx_byte[SYNC_BIT]) begin
                    packet_phase  <= PH_HEAD;
                    last_x        <= {head_byte[5:3], middle_byte};
                    last_y        <= {head_byte[2:0], rx_byte[6:0]};
                    pressed       <= head_byte[PEN_BIT];
                    release_count <= '0;
                    rep           <= 1'b1;
                    rep_pen       <= head_byte[PEN_BIT];
                  end
                end
                default: begin
                  // awaiting a head byte; the unused phase acts the same
                  if (rx_byte[SYNC_BIT]) begin
                    head_byte    <= rx_byte;
                    packet_phase <= PH_MIDDLE;
                  end else begin
                    packet_phase <= PH_HEAD;
                  end
                end
              endcase
            end else if (pressed) begin
              // forced pen release after too many idle ticks
              if (release_count > {1'b0, release_limit}) begin
                pressed       <= 1'b0;
                release_count <= '0;
                rep           <= 1'b1;
              end else begin
                release_count <= release_count + 9'd1;
              end
            end

            // pick the tick interval and the divisor; asleep or zero period
            // leaves the limits unscaled, which a divide by one gives
            if (sleeping_next) begin
              tick_ms <= SLEEP_TICK_MS;
              div_den <= 4'd1;
            end else if (eff_period != 4'd0) begin
              tick_ms <= {3'd0, eff_period};
              div_den <= eff_period;
            end else begin
              tick_ms <= 7'd1;
              div_den <= 4'd1;
            end

            div_quo <= {{(DIV_BITS-8){1'b0}}, release_wait};
            div_rem <= '0;
            div_cnt <= '0;
            div_sel <= 1'b0;
            state   <= S_DIV;
          end
        end

        S_DIV: begin
          if (div_cnt == DIV_LAST) begin
            div_cnt <= '0;
            div_rem <= '0;
            if (!div_sel) begin
              release_limit <= div_quo_next[7:0];
              div_quo       <= sleep_wait;
              div_sel       <= 1'b1;
            end else begin
              sleep_limit <= div_quo_next;
              state       <= S_FIN;
            end
          end else begin
            div_quo <= div_quo_next;
            div_rem <= div_rem_next;
            div_cnt <= div_cnt + 4'd1;
          end
        end

        S_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            if (fin_sleep) begin
              sleeping <= 1'b1;
            end else begin
              idle_count <= idle_count + 14'd1;
            end
            if (fin_poll) begin
              poll_count <= '0;
            end else begin
              poll_count <= poll_count + 17'd1;
            end

            report_valid <= rep;
            pen_down     <= rep && rep_pen;
            pos_x        <= rep ? ~last_x : '0;
            pos_y        <= rep ? last_y : '0;
            asleep       <= sleeping || fin_sleep;
            next_tick_ms <= tick_ms;
            status_poll  <= fin_poll;
            state        <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  // Assertions
  `TPT_CHECK(a_accept_starts_div, accept |=> (state == S_DIV), "accepted tick did not start divider")
  `TPT_CHECK(a_div_count_bound, (state == S_DIV) |-> (div_cnt <= DIV_LAST), "divider step count overran")
  `TPT_CHECK(a_div_rem_bound, (state == S_DIV) |-> (div_rem < div_den), "divider remainder not below divisor")
  `TPT_CHECK(a_out_held, ($fell(out_valid) && !$past(rst)) |-> !$past(out_stall), "result dropped while stalled")
  `TPT_CHECK(a_no_overwrite, (out_valid && out_stall && (state == S_FIN)) |=> (state == S_FIN), "result overwritten under stall")
  `TPT_CHECK_ALWAYS(a_reset_idle, rst |=> ((state == S_IDLE) && !out_valid), "reset left sequencer busy")

endmodule

// File: tb/sv/touch_packet_tracker_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Touch packet tracker testbench
// Drives polling-tick requests through the tracker with random gaps and
// output stalls. Every accepted tick is run through a local tracker model,
// and each result is checked field by field in order.
// ----------------------------------------------------------------------------
module touch_packet_tracker_test import tpt_pkg::*; ();

  localparam int WATCHDOG_LIMIT = 1000;  // cycles without any handshake
  localparam int SETTLE_CYCLES  = 40;
  localparam int PRINT_CAP      = 30;
  localparam logic [COORD_BITS-1:0] COORD_MAX = '1;

  typedef struct packed {
    logic       byte_present;
    logic [7:0] rx_byte;
  } tick_req_t;

  typedef struct packed {
    logic                  report_valid;
    logic                  pen_down;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  asleep;
    logic [6:0]            next_tick_ms;
    logic                  status_poll;
  } touch_result_t;

  // Clock, reset and block inputs, all known from time zero
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic write_en = 1'b0;
  logic [1:0] write_index = REG_SCAN_PERIOD;
  logic [15:0] write_data = '0;
  logic in_valid = 1'b0;
  logic byte_present = 1'b0;
  logic [7:0] rx_byte = '0;
  logic out_stall = 1'b0;

  logic in_stall;
  logic out_valid;
  logic report_valid;
  logic pen_down;
  logic [COORD_BITS-1:0] pos_x;
  logic [COORD_BITS-1:0] pos_y;
  logic asleep;
  logic [6:0] next_tick_ms;
  logic status_poll;

  touch_packet_tracker uut (
    .clk          (clk),
    .rst          (rst),
    .write_en     (write_en),
    .write_index  (write_index),
    .write_data   (write_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .byte_present (byte_present),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .report_valid (report_valid),
    .pen_down     (pen_down),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .asleep       (asleep),
    .next_tick_ms (next_tick_ms),
    .status_poll  (status_poll)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Register copies held by the tracker model
  logic [3:0]  cfg_period  = RST_PERIOD;
  logic [7:0]  cfg_release = RST_RELEASE;
  logic [12:0] cfg_sleep   = RST_SLEEP;
  logic [15:0] cfg_poll    = RST_POLL;

  // Tracker model state, at its reset values
  logic [1:0]            phase         = PH_HEAD;
  logic [7:0]            head_byte     = '0;
  logic [6:0]            middle_byte   = '0;
  logic [COORD_BITS-1:0] last_x        = '0;
  logic [COORD_BITS-1:0] last_y        = '0;
  logic                  pressed       = 1'b0;
  logic [8:0]            release_count = '0;
  logic [7:0]            release_limit = RST_RELEASE;
  logic [12:0]           sleep_limit   = RST_SLEEP;
  logic [13:0]           idle_count    = '0;
  logic                  sleeping      = 1'b0;
  logic [16:0]           poll_count    = '0;

  tick_req_t     pending_ticks[$];
  touch_result_t expected_results[$];

  int          mismatch_count = 0;
  int          result_count = 0;
  int          quiet_cycles = 0;
  int unsigned send_gap = 0;
  int unsigned recv_hold = 0;
  bit          send_hold;
  bit          steady = 1'b0;  // phase runs with no gaps and no stalls
  tick_req_t     next_tick;
  touch_result_t want;

  // Advance the tracker model by one tick and return the result it gives.
  function automatic touch_result_t track_tick(input logic have, input logic [7:0] b);
    touch_result_t r;
    logic [3:0] p;
    r = '0;
    if (have) begin
      // any byte wakes the block and restarts the idle count
      sleeping = 1'b0;
      idle_count = '0;
      if (phase == PH_MIDDLE) begin
        if (!b[SYNC_BIT]) begin
          middle_byte = b[6:0];
          phase = PH_LAST;
        end
      end else if (phase == PH_LAST) begin
        if (!b[SYNC_BIT]) begin
          phase = PH_HEAD;
          last_x = {head_byte[5:3], middle_byte};
          last_y = {head_byte[2:0], b[6:0]};
          pressed = head_byte[PEN_BIT];
          release_count = '0;
          r.report_valid = 1'b1;
          r.pen_down = pressed;
        end
      end else if (b[SYNC_BIT]) begin
        head_byte = b;
        phase = PH_MIDDLE;
      end else begin
        phase = PH_HEAD;
      end
    end else if (pressed) begin
      // count quiet ticks; past the limit, force a pen-up report
      if (release_count > release_limit) begin
        pressed = 1'b0;
        release_count = '0;
        r.report_valid = 1'b1;
        r.pen_down = 1'b0;
      end else begin
        release_count++;
      end
    end

    // pick interval and limits; asleep means unscaled limits and slow ticks
    p = (cfg_period > MAX_PERIOD) ? MAX_PERIOD : cfg_period;
    if (sleeping) begin
      r.next_tick_ms = SLEEP_TICK_MS;
      release_limit = cfg_release;
      sleep_limit = cfg_sleep;
    end else if (p != '0) begin
      r.next_tick_ms = 7'(p);
      release_limit = cfg_release / p;
      sleep_limit = cfg_sleep / p;
    end else begin
      r.next_tick_ms = 7'd1;
      release_limit = cfg_release;
      sleep_limit = cfg_sleep;
    end

    if (idle_count > sleep_limit) sleeping = 1'b1;
    else idle_count++;

    if (poll_count > cfg_poll) begin
      poll_count = '0;
      r.status_poll = 1'b1;
    end else begin
      poll_count++;
    end

    if (r.report_valid) begin
      r.pos_x = COORD_MAX - last_x;
      r.pos_y = last_y;
    end
    r.asleep = sleeping;
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    return steady ? 0 : $urandom_range(0, 10);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] exp_val);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("result %0d: %s is %0h, expected %0h", result_count, what, got, exp_val);
  endtask

  // --------------------------------------------------------------------------
  // Request driver: pop ticks from the pending queue, hold each one until the
  // block takes it, then wait a random gap. Predict at the accepting edge.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      send_hold = in_valid;
      if (in_valid && !in_stall) begin
        expected_results.push_back(track_tick(byte_present, rx_byte));
        send_hold = 1'b0;
        send_gap = draw_wait();
      end
      // a stalled request keeps valid and payload as they are
      if (!send_hold) begin
        if (send_gap != 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          next_tick = pending_ticks.pop_front();
          byte_present <= next_tick.byte_present;
          rx_byte <= next_tick.rx_byte;
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted result with the oldest expected
  // one, then stall the output for a random number of cycles.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 16'(report_valid), 16'h0);
        end else begin
          want = expected_results.pop_front();
          if (report_valid !== want.report_valid)
            report_mismatch("report_valid", 16'(report_valid), 16'(want.report_valid));
          if (pen_down !== want.pen_down)
            report_mismatch("pen_down", 16'(pen_down), 16'(want.pen_down));
          if (pos_x !== want.pos_x)
            report_mismatch("pos_x", 16'(pos_x), 16'(want.pos_x));
          if (pos_y !== want.pos_y)
            report_mismatch("pos_y", 16'(pos_y), 16'(want.pos_y));
          if (asleep !== want.asleep)
            report_mismatch("asleep", 16'(asleep), 16'(want.asleep));
          if (next_tick_ms !== want.next_tick_ms)
            report_mismatch("next_tick_ms", 16'(next_tick_ms), 16'(want.next_tick_ms));
          if (status_poll !== want.status_poll)
            report_mismatch("status_poll", 16'(status_poll), 16'(want.status_poll));
        end
        recv_hold = draw_wait();
      end else if (recv_hold != 0) begin
        recv_hold--;
      end
      out_stall <= (recv_hold != 0);
    end
  end

  // Watchdog: end the run if no handshake of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || write_en) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic add_tick(input logic present, input logic [7:0] b);
    tick_req_t t;
    t.byte_present = present;
    t.rx_byte = b;
    pending_ticks.push_back(t);
  endtask

  // Queue a well-formed packet for raw coordinates x and y.
  task automatic add_packet(input logic pen, input logic [COORD_BITS-1:0] x,
                            input logic [COORD_BITS-1:0] y);
    add_tick(1'b1, {1'b1, pen, x[9:7], y[9:7]});
    add_tick(1'b1, {1'b0, x[6:0]});
    add_tick(1'b1, {1'b0, y[6:0]});
  endtask

  // Queue empty ticks; the byte lines carry junk that must be ignored.
  task automatic add_idle(input int count);
    repeat (count) add_tick(1'b0, 8'($urandom));
  endtask

  // Mostly clean packets with random content, plus broken sequences and noise.
  task automatic add_traffic(input int count);
    int unsigned pick;
    int target;
    target = pending_ticks.size() + count;
    while (pending_ticks.size() < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        add_packet(1'($urandom), 10'($urandom), 10'($urandom));
        // long quiet runs now and then, to reach release and sleep
        add_idle(($urandom_range(0, 7) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 3));
      end else if (pick < 68) begin
        add_idle($urandom_range(1, 12));
      end else if (pick < 78) begin
        // sync byte cutting into a packet: drop it and finish the packet
        add_tick(1'b1, {1'b1, 7'($urandom)});
        if ($urandom_range(0, 1)) add_tick(1'b1, {1'b0, 7'($urandom)});
        add_tick(1'b1, {1'b1, 7'($urandom)});
        add_tick(1'b1, {1'b0, 7'($urandom)});
        add_tick(1'b1, {1'b0, 7'($urandom)});
      end else if (pick < 86) begin
        // stray byte while a head byte is awaited
        add_tick(1'b1, {1'b0, 7'($urandom)});
      end else if (pick < 93) begin
        // packet cut short by quiet ticks
        add_tick(1'b1, {1'b1, 7'($urandom)});
        if ($urandom_range(0, 1)) add_tick(1'b1, {1'b0, 7'($urandom)});
        add_idle($urandom_range(0, 4));
      end else begin
        add_tick(1'($urandom), 8'($urandom));
      end
    end
  endtask

  // Hold until every queued request has gone and every result has come back.
  // Look at the falling edge, once all updates of the rising edge have landed.
  task automatic drain();
    while (pending_ticks.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] index, input logic [15:0] data);
    @(posedge clk);
    write_en <= 1'b1;
    write_index <= index;
    write_data <= data;
    case (index)
      REG_SCAN_PERIOD:   cfg_period = data[3:0];
      REG_RELEASE_WAIT:  cfg_release = data[7:0];
      REG_SLEEP_WAIT:    cfg_sleep = data[12:0];
      REG_POLL_INTERVAL: cfg_poll = data;
      default: ;
    endcase
    @(posedge clk);
    write_en <= 1'b0;
  endtask

  // One phase: program all registers while idle, run traffic, drain.
  // The drain makes the sender pause until every result is back.
  task automatic run_phase(input logic [3:0] period, input logic [7:0] rel,
                           input logic [12:0] slp, input logic [15:0] poll,
                           input int count);
    steady = ($urandom_range(0, 3) == 0);
    write_reg(REG_SCAN_PERIOD, 16'(period));
    write_reg(REG_RELEASE_WAIT, 16'(rel));
    write_reg(REG_SLEEP_WAIT, 16'(slp));
    write_reg(REG_POLL_INTERVAL, poll);
    add_traffic(count);
    drain();
  endtask

  // --------------------------------------------------------------------------
  // Sequence: reset, directed ticks at reset settings, then random phases
  // over a spread of register settings, extremes included.
  // --------------------------------------------------------------------------
  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // junk on the byte lines of an empty tick
    add_tick(1'b0, 8'hFF);
    // bytes without the sync bit while a head byte is awaited
    add_tick(1'b1, 8'h00);
    add_tick(1'b1, 8'h7F);
    // coordinate extremes, pen down and up
    add_packet(1'b1, 10'd0, 10'd0);
    add_packet(1'b0, 10'd1023, 10'd1023);
    // sync bytes in the middle and last positions get dropped
    add_tick(1'b1, 8'hC5);
    add_tick(1'b1, 8'hFF);
    add_tick(1'b1, 8'h2A);
    add_tick(1'b1, 8'hAA);
    add_tick(1'b1, 8'h55);
    // pen down, then enough quiet ticks to force a release
    add_packet(1'b1, 10'h2AA, 10'h155);
    add_idle(7);
    drain();

    run_phase(RST_PERIOD, RST_RELEASE, RST_SLEEP, RST_POLL, 150);
    run_phase(4'd0, 8'd0, 13'd0, 16'd0, 120);
    run_phase(4'd10, 8'd255, 13'd8191, 16'd65535, 100);
    run_phase(4'd15, 8'd37, 13'd40, 16'd7, 150);
    run_phase(4'd1, 8'd3, 13'd12, 16'd20, 150);
    repeat (3)
      run_phase(4'($urandom_range(0, 15)), 8'($urandom_range(0, 63)),
                13'($urandom_range(0, 300)), 16'($urandom_range(0, 60)), 90);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results missing", 16'h0, 16'(expected_results.size()));
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/tpt_pkg.sv
design/touch_packet_tracker.sv
tb/sv/touch_packet_tracker_test.sv
